### design/rcf_pkg.sv
// Shared types and constants of the 3x3 RGB convolution filter.
package rcf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int CHANNELS   = 3;
   localparam int CHAN_W     = 8;
   localparam int COUNT_W    = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int WIN_COLS   = 3;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;

   // Reciprocal of nine in 16 fractional bits, rounded up. It gives the exact
   // floor of sum / 9 for every sum of nine 8-bit values.
   localparam int BLUR_RECIP = 7282;
   localparam int BLUR_SHIFT = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILTER_MODE  = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_BLUR    = 2'd0,
      MODE_EDGE    = 2'd1,
      MODE_SHARPEN = 2'd2
   } mode_type;

   // Channel 0 is red, 1 green, 2 blue.
   typedef logic [CHANNELS-1:0][CHAN_W-1:0] pixel_type;
   typedef logic [CHANNELS-1:0][CHAN_W:0]   pair_type;

   typedef struct packed {
      pixel_type top;
      pixel_type mid;
      pixel_type bot;
   } column_type;

   typedef struct packed {
      pixel_type prev;
      pixel_type prev2;
   } line_word_type;

   typedef struct packed {
      logic               emit;
      logic [ROW_W-1:0]   row;
      logic [COUNT_W-1:0] col;
      logic               last;
   } info_type;

endpackage

### design/rcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/rcf_col_cell.sv
// One column cell of the 3x3 window: holds three pixels and passes them on.
module rcf_col_cell (
   input  logic                clock,
   input  logic                shift_en,
   input  rcf_pkg::column_type col_in,
   output rcf_pkg::column_type col_out,
   output rcf_pkg::pair_type   pair_out
);

   rcf_pkg::column_type col_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

   // Sum of the upper and lower pixel, shared by the box, cross and corner terms.
   always_comb begin
      for (int ch = 0; ch < rcf_pkg::CHANNELS; ch++) begin
         pair_out[ch] = {1'b0, col_ff.top[ch]} + {1'b0, col_ff.bot[ch]};
      end
   end

endmodule

### design/rgb_conv3x3_filter.sv
// Top level of the 3x3 RGB convolution filter on a raster pixel stream.
// A pixel's result passes the line store read, the window shift, the sums and the output
// register, in that order, before it shows on rsp_tvalid.
// Throughput: one pixel per clock unless rsp_tready stalls the output, set by the line
// store that is read and written once per cycle; border pixels give no result and leave a
// bubble in the output stream. Reset clears the position counters and stage valid bits and
// sets blur mode and the largest image size; the line stores and the window are not cleared.
module rgb_conv3x3_filter (
   input  logic                               clock,
   input  logic                               reset,
   // Pixel input.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [rcf_pkg::REQ_DATA_W-1:0]     req_tdata,  // red_in, green_in, blue_in
   input  logic                               req_tuser,  // frame_start
   // Filtered pixel output.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rcf_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // red_out, green_out, blue_out,
                                                          // center_row, center_col, zero pad
   output logic                               rsp_tlast,  // frame_last
   // Configuration writes.
   input  logic                               csr_wr_en,
   input  logic [rcf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rcf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam logic [rcf_pkg::CSR_DATA_W-1:0] WIDTH_LIMIT =
      rcf_pkg::CSR_DATA_W'(rcf_pkg::MAX_WIDTH);
   localparam logic [rcf_pkg::CSR_DATA_W-1:0] HEIGHT_LIMIT =
      rcf_pkg::CSR_DATA_W'(rcf_pkg::MAX_HEIGHT);
   localparam int PAD_W = rcf_pkg::RSP_DATA_W - rcf_pkg::CHANNELS * rcf_pkg::CHAN_W
                          - rcf_pkg::ROW_W - rcf_pkg::COUNT_W;

   // Clamp a written size into the supported range and keep it minus one, which is
   // the last column or row index the counters compare against.
   function automatic logic [rcf_pkg::COUNT_W-1:0] size_m1(
      input logic [rcf_pkg::CSR_DATA_W-1:0] v,
      input logic [rcf_pkg::CSR_DATA_W-1:0] limit
   );
      logic [rcf_pkg::CSR_DATA_W-1:0] m;
      if (v < 11'd3) begin
         m = 11'd2;
      end else if (v > limit) begin
         m = limit - 11'd1;
      end else begin
         m = v - 11'd1;
      end
      size_m1 = m[rcf_pkg::COUNT_W-1:0];
   endfunction

   // One output channel from the center, cross and corner sums of the window.
   function automatic logic [rcf_pkg::CHAN_W-1:0] filter_chan(
      input rcf_pkg::mode_type          mode,
      input logic [rcf_pkg::CHAN_W-1:0] c,
      input logic [9:0]                 cross_sum,
      input logic [9:0]                 corner
   );
      logic [11:0]        total;
      logic [23:0]        prod;
      logic signed [12:0] c_s;
      logic signed [12:0] cross_s;
      logic signed [12:0] corner_s;
      logic signed [12:0] acc;
      total    = {4'b0, c} + {2'b0, cross_sum} + {2'b0, corner};
      prod     = 24'(total) * 24'(rcf_pkg::BLUR_RECIP);
      c_s      = signed'({5'b0, c});
      cross_s  = signed'({3'b0, cross_sum});
      corner_s = signed'({3'b0, corner});
      unique case (mode)
         rcf_pkg::MODE_EDGE: begin
            acc = (c_s <<< 3) - cross_s - corner_s;
         end
         rcf_pkg::MODE_SHARPEN: begin
            acc = (c_s <<< 2) + c_s - cross_s;
         end
         default: begin
            acc = signed'({5'b0, prod[rcf_pkg::BLUR_SHIFT +: rcf_pkg::CHAN_W]});
         end
      endcase
      if (acc < 13'sd0) begin
         filter_chan = '0;
      end else if (acc > 13'sd255) begin
         filter_chan = '1;
      end else begin
         filter_chan = acc[rcf_pkg::CHAN_W-1:0];
      end
   endfunction

   // Configuration registers.
   rcf_pkg::mode_type            mode_ff;
   logic [rcf_pkg::COUNT_W-1:0]  wm1_ff;
   logic [rcf_pkg::ROW_W-1:0]    hm1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= rcf_pkg::MODE_BLUR;
         wm1_ff  <= size_m1(WIDTH_LIMIT, WIDTH_LIMIT);
         hm1_ff  <= size_m1(HEIGHT_LIMIT, HEIGHT_LIMIT);
      end else if (csr_wr_en) begin
         unique case (rcf_pkg::csr_index_type'(csr_index))
            rcf_pkg::CSR_FILTER_MODE: begin
               mode_ff <= rcf_pkg::mode_type'(csr_wdata[1:0]);
            end
            rcf_pkg::CSR_IMAGE_WIDTH: begin
               wm1_ff <= size_m1(csr_wdata, WIDTH_LIMIT);
            end
            rcf_pkg::CSR_IMAGE_HEIGHT: begin
               hm1_ff <= size_m1(csr_wdata, HEIGHT_LIMIT);
            end
            default: begin
               // Writes beyond the register list are dropped.
            end
         endcase
      end
   end

   // Stage handshakes. Each stage loads when it is empty or its content moves on,
   // so bubbles close up and a waiting result blocks new pixels only when the stages are full.
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s3_valid_ff;
   logic rsp_valid_ff;
   rcf_pkg::info_type s1_info_ff;
   rcf_pkg::info_type s2_info_ff;
   rcf_pkg::info_type s3_info_ff;

   logic s4_load;
   logic s3_load;
   logic s2_load;
   logic s1_load;
   logic s1_move;
   logic req_xfer;

   assign s4_load    = !rsp_valid_ff || rsp_tready;
   assign s3_load    = !s3_valid_ff || s4_load;
   // A window entry that gives no result is simply dropped when the next one arrives.
   assign s2_load    = !s2_valid_ff || !s2_info_ff.emit || s3_load;
   assign s1_load    = !s1_valid_ff || s2_load;
   assign s1_move    = s1_valid_ff && s2_load;
   assign req_tready = s1_load;
   assign req_xfer   = req_tvalid && req_tready;

   // Position of the incoming pixel. A frame start forces row 0, column 0.
   logic [rcf_pkg::COUNT_W-1:0] col_ff;
   logic [rcf_pkg::COUNT_W-1:0] col_in;
   logic [rcf_pkg::ROW_W-1:0]   row_ff;
   logic [rcf_pkg::ROW_W-1:0]   row_in;
   logic [rcf_pkg::COUNT_W-1:0] cur_col;
   logic [rcf_pkg::ROW_W-1:0]   cur_row;
   rcf_pkg::info_type           cur_info;

   always_comb begin
      cur_col = req_tuser ? '0 : col_ff;
      cur_row = req_tuser ? '0 : row_ff;
      cur_info.emit = (cur_row >= rcf_pkg::ROW_W'(2)) && (cur_col >= rcf_pkg::COUNT_W'(2));
      cur_info.row  = cur_row - rcf_pkg::ROW_W'(1);
      cur_info.col  = cur_col - rcf_pkg::COUNT_W'(1);
      cur_info.last = (cur_row == hm1_ff) && (cur_col == wm1_ff);
      if (cur_col >= wm1_ff) begin
         col_in = '0;
         row_in = (cur_row >= hm1_ff) ? '0 : cur_row + rcf_pkg::ROW_W'(1);
      end else begin
         col_in = cur_col + rcf_pkg::COUNT_W'(1);
         row_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_xfer) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage 1: both line stores share one RAM word per column, read on the transfer.
   // A pixel at the same column as the one just ahead of it (a frame start right after
   // column zero) takes the word being written through a bypass.
   rcf_pkg::pixel_type            s1_px_ff;
   logic [rcf_pkg::COUNT_W-1:0]   s1_addr_ff;
   logic                          fwd_ff;
   rcf_pkg::line_word_type        fwd_word_ff;
   rcf_pkg::line_word_type        ram_q;
   rcf_pkg::line_word_type        s1_word;
   rcf_pkg::line_word_type        wr_word;
   logic                          fwd_in;

   assign s1_word      = fwd_ff ? fwd_word_ff : ram_q;
   assign wr_word.prev  = s1_px_ff;
   assign wr_word.prev2 = s1_word.prev;
   assign fwd_in       = s1_move && (s1_addr_ff == cur_col);

   rcf_ram #(
      .WIDTH ($bits(rcf_pkg::line_word_type)),
      .DEPTH (rcf_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_word),
      .rd_en   (req_xfer),
      .rd_addr (cur_col),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= req_tvalid;
         fwd_ff      <= req_tvalid && fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_px_ff    <= rcf_pkg::pixel_type'(req_tdata);
         s1_addr_ff  <= cur_col;
         s1_info_ff  <= cur_info;
         fwd_word_ff <= wr_word;
      end
   end

   // Stage 2: the window, a chain of three column cells. The newest column enters
   // at the right end and every cell hands its column to its left neighbor.
   rcf_pkg::column_type col_chain_in [rcf_pkg::WIN_COLS];
   rcf_pkg::column_type col_q        [rcf_pkg::WIN_COLS];
   rcf_pkg::pair_type   pair_q       [rcf_pkg::WIN_COLS];

   assign col_chain_in[rcf_pkg::WIN_COLS-1].top = s1_word.prev2;
   assign col_chain_in[rcf_pkg::WIN_COLS-1].mid = s1_word.prev;
   assign col_chain_in[rcf_pkg::WIN_COLS-1].bot = s1_px_ff;

   for (genvar k = 0; k < rcf_pkg::WIN_COLS; k++) begin : g_cell
      if (k < rcf_pkg::WIN_COLS - 1) begin : g_link
         assign col_chain_in[k] = col_q[k+1];
      end
      rcf_col_cell u_cell (
         .clock    (clock),
         .shift_en (s1_move),
         .col_in   (col_chain_in[k]),
         .col_out  (col_q[k]),
         .pair_out (pair_q[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_load) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_info_ff <= s1_info_ff;
      end
   end

   // Stage 3: center, cross and corner sums of each channel.
   logic [rcf_pkg::CHANNELS-1:0][rcf_pkg::CHAN_W-1:0] center_in;
   logic [rcf_pkg::CHANNELS-1:0][9:0]                 cross_in;
   logic [rcf_pkg::CHANNELS-1:0][9:0]                 corner_in;
   logic [rcf_pkg::CHANNELS-1:0][rcf_pkg::CHAN_W-1:0] s3_center_ff;
   logic [rcf_pkg::CHANNELS-1:0][9:0]                 s3_cross_ff;
   logic [rcf_pkg::CHANNELS-1:0][9:0]                 s3_corner_ff;

   always_comb begin
      for (int ch = 0; ch < rcf_pkg::CHANNELS; ch++) begin
         center_in[ch] = col_q[1].mid[ch];
         cross_in[ch]  = {1'b0, pair_q[1][ch]} + {2'b0, col_q[0].mid[ch]}
                         + {2'b0, col_q[2].mid[ch]};
         corner_in[ch] = {1'b0, pair_q[0][ch]} + {1'b0, pair_q[2][ch]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_load) begin
         s3_valid_ff <= s2_valid_ff && s2_info_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_load) begin
         s3_center_ff <= center_in;
         s3_cross_ff  <= cross_in;
         s3_corner_ff <= corner_in;
         s3_info_ff   <= s2_info_ff;
      end
   end

   // Stage 4: kernel arithmetic, clamp and the output register.
   rcf_pkg::pixel_type          rsp_px_in;
   rcf_pkg::pixel_type          rsp_px_ff;
   logic [rcf_pkg::ROW_W-1:0]   rsp_row_ff;
   logic [rcf_pkg::COUNT_W-1:0] rsp_col_ff;
   logic                        rsp_last_ff;

   always_comb begin
      for (int ch = 0; ch < rcf_pkg::CHANNELS; ch++) begin
         rsp_px_in[ch] = filter_chan(mode_ff, s3_center_ff[ch], s3_cross_ff[ch],
                                     s3_corner_ff[ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s4_load) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_load) begin
         rsp_px_ff   <= rsp_px_in;
         rsp_row_ff  <= s3_info_ff.row;
         rsp_col_ff  <= s3_info_ff.col;
         rsp_last_ff <= s3_info_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_col_ff, rsp_row_ff, rsp_px_ff};
   assign rsp_tlast  = rsp_last_ff;

   // The frame's last result sits at the last interior column.
   a_last_col : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_col_ff == wm1_ff - rcf_pkg::COUNT_W'(1)))
      else $error("last result not at the last interior column");

   // Only interior centers reach the output.
   a_interior : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_row_ff != '0 && rsp_col_ff != '0))
      else $error("border center reached the output");

   // The bypass only ever serves a pixel that is held in stage 1.
   a_fwd_valid : assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> s1_valid_ff)
      else $error("line store bypass without a pixel in stage 1");

   // A frame start places the next pixel at row 0, column 1.
   a_frame_start : assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_tuser) |=> (col_ff == rcf_pkg::COUNT_W'(1) && row_ff == '0))
      else $error("position counters wrong after a frame start");

endmodule
